// ----- rtl/mts_pkg.sv -----
// Shared constants, codes and control types of the melody tone sequencer.
`default_nettype none
package mts_pkg;

    // Note table geometry
    localparam int NOTE_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int ENTRY_W    = 32;

    // Field widths of the item and result channels
    localparam int ACT_W  = 3;
    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int LEN_W  = 7;
    localparam int MODE_W = 2;

    // Configuration register widths and index width
    localparam int CLK_W     = 25;
    localparam int TPM_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Half period divider sizes
    localparam int HP_W      = 16;
    localparam int QUO_W     = CLK_W;
    localparam int DIVS_W    = FREQ_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PLAY   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PAUSE  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RESUME = 3'd5;
    localparam logic [ACT_W-1:0] ACT_TONE   = 3'd6;

    // Melody modes
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_MS = 2'd1;

    // Configuration reset values
    localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 25'd16000000;
    localparam logic [TPM_W-1:0] TICKS_MS_RST = 16'd16000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;       // apply the accepted item
        logic note_eval;  // note table entry is on the read port
        logic load_out;   // capture the result item
    } mts_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic item_read;  // the offered item needs a note table read
        logic item_div;   // the offered item starts a tone
        logic note_div;   // the note entry starts a tone
        logic div_done;   // half period division finished
    } mts_sts_t;

endpackage
`default_nettype wire

// ----- rtl/mts_item_if.sv -----
// Input item channel of the melody tone sequencer.
`default_nettype none
interface mts_item_if
    import mts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] note_slot;
    logic [FREQ_W-1:0] frequency;
    logic [DUR_W-1:0]  duration_ms;
    logic [LEN_W-1:0]  melody_length;
    logic              repeat_flag;

    modport source (
        output valid, action, note_slot, frequency, duration_ms, melody_length,
               repeat_flag,
        input  ready
    );
    modport sink (
        input  valid, action, note_slot, frequency, duration_ms, melody_length,
               repeat_flag,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/mts_result_if.sv -----
// Result item channel of the melody tone sequencer.
`default_nettype none
interface mts_result_if
    import mts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              pin_level;
    logic              tone_on;
    logic [MODE_W-1:0] play_mode;
    logic [LEN_W-1:0]  current_note;

    modport source (
        output valid, pin_level, tone_on, play_mode, current_note,
        input  ready
    );
    modport sink (
        input  valid, pin_level, tone_on, play_mode, current_note,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/mts_cfg_if.sv -----
// Configuration write channel of the melody tone sequencer.
`default_nettype none
interface mts_cfg_if
    import mts_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CLK_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/mts_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/mts_div.sv -----
// Restoring divider, one quotient bit per cycle, for the tone half period.
`default_nettype none
module mts_div
    import mts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QUO_W-1:0]  dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   done,
    output logic      [QUO_W-1:0]  quotient
);

    logic [DIVS_W-1:0]    rem_reg;
    logic [DIVS_W-1:0]    rem_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [DIVS_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIVS_W:0]      trial;
    logic                 fits;

    // One restoring step: shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DIV_CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/mts_dp.sv -----
// Datapath: configuration, melody and tone state, note table and divider.
`default_nettype none
module mts_dp
    import mts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mts_cmd_t             cmd,
    output mts_sts_t                  sts,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CLK_W-1:0]     cfg_data,
    input  wire logic [ACT_W-1:0]     action,
    input  wire logic [SLOT_W-1:0]    note_slot,
    input  wire logic [FREQ_W-1:0]    frequency,
    input  wire logic [DUR_W-1:0]     duration_ms,
    input  wire logic [LEN_W-1:0]     melody_length,
    input  wire logic                 repeat_flag,
    output logic                      pin_level,
    output logic                      tone_on,
    output logic      [MODE_W-1:0]    play_mode,
    output logic      [LEN_W-1:0]     current_note
);

    // Configuration registers
    logic [CLK_W-1:0] clock_hz_reg;
    logic [TPM_W-1:0] tpm_reg;

    // Melody and tone state
    logic [MODE_W-1:0] mode_reg,      mode_next;
    logic [LEN_W-1:0]  pos_reg,       pos_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic              rep_reg,       rep_next;
    logic              started_reg,   started_next;
    logic [DUR_W-1:0]  note_el_reg,   note_el_next;
    logic [TPM_W-1:0]  pre_reg,       pre_next;
    logic              active_reg,    active_next;
    logic              timed_reg,     timed_next;
    logic [DUR_W-1:0]  tone_el_reg,   tone_el_next;
    logic [DUR_W-1:0]  limit_reg,     limit_next;
    logic [HP_W-1:0]   hp_reg,        hp_next;
    logic [HP_W-1:0]   tcount_reg,    tcount_next;
    logic              pin_reg,       pin_next;
    logic [DUR_W-1:0]  pend_dur_reg,  pend_dur_next;

    // Result registers
    logic              out_pin_reg;
    logic              out_tone_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic [LEN_W-1:0]  out_note_reg;

    logic                boundary;
    logic                end_of_tune;
    logic                tune_over;
    logic                tone_kill;
    logic [DUR_W-1:0]    tone_el_inc;
    logic [DUR_W-1:0]    note_el_inc;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [FREQ_W-1:0]   entry_freq;
    logic [DUR_W-1:0]    entry_dur;
    logic                div_start;
    logic [FREQ_W-1:0]   div_freq;
    logic                div_done;
    logic [QUO_W-1:0]    div_quo;
    logic                hp_ok;

    // Millisecond boundary and saturating elapsed counters
    assign boundary    = ({1'b0, pre_reg} + 17'd1) >= {1'b0, tpm_reg};
    assign tone_el_inc = (&tone_el_reg) ? tone_el_reg : tone_el_reg + 1'b1;
    assign note_el_inc = (&note_el_reg) ? note_el_reg : note_el_reg + 1'b1;

    // A new note is due but the melody has run past its last note
    assign end_of_tune = !started_reg && (pos_reg >= len_reg);
    assign tune_over   = (mode_reg == MODE_PLAYING) && end_of_tune && !rep_reg;

    // Note table entry fields
    assign entry_freq = ram_rd_data[ENTRY_W-1:DUR_W];
    assign entry_dur  = ram_rd_data[DUR_W-1:0];

    // Status towards the controller
    assign sts.item_read = (action == ACT_TICK) && boundary
                           && (mode_reg == MODE_PLAYING) && !tune_over;
    assign sts.item_div  = (action == ACT_TONE) && (frequency != '0);
    assign sts.note_div  = !started_reg && (entry_freq != '0);
    assign sts.div_done  = div_done;

    // Note table access: the read address is the note a boundary tick will use
    assign ram_we      = cmd.exec && (action == ACT_WRITE)
                         && (32'(note_slot) < NOTE_SLOTS);
    assign ram_rd_addr = end_of_tune ? '0 : pos_reg[SLOT_W-1:0];

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NOTE_SLOTS)
    ) u_note_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (note_slot),
        .wr_data ({frequency, duration_ms}),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Half period = clock / (2 * frequency)
    assign div_start = (cmd.exec && sts.item_div) || (cmd.note_eval && sts.note_div);
    assign div_freq  = cmd.exec ? frequency : entry_freq;
    assign hp_ok     = (div_quo != '0) && (div_quo[QUO_W-1:HP_W] == '0);

    mts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_hz_reg),
        .divisor  ({div_freq, 1'b0}),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state of the melody and tone registers
    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        rep_next      = rep_reg;
        started_next  = started_reg;
        note_el_next  = note_el_reg;
        pre_next      = pre_reg;
        active_next   = active_reg;
        timed_next    = timed_reg;
        tone_el_next  = tone_el_reg;
        limit_next    = limit_reg;
        hp_next       = hp_reg;
        tcount_next   = tcount_reg;
        pin_next      = pin_reg;
        pend_dur_next = pend_dur_reg;
        tone_kill     = 1'b0;

        if (cmd.exec)
        begin
            unique case (action)
                ACT_TICK:
                begin
                    // Square wave: toggle after half period plus one ticks
                    if (active_reg)
                    begin
                        if (tcount_reg >= hp_reg)
                        begin
                            tcount_next = '0;
                            pin_next    = !pin_reg;
                        end
                        else
                        begin
                            tcount_next = tcount_reg + 1'b1;
                        end
                    end
                    if (boundary)
                    begin
                        pre_next     = '0;
                        tone_el_next = tone_el_inc;
                        note_el_next = note_el_inc;
                        if (active_reg && timed_reg && (tone_el_inc >= limit_reg))
                        begin
                            tone_kill = 1'b1;
                        end
                        if ((mode_reg == MODE_PLAYING) && end_of_tune)
                        begin
                            if (rep_reg)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                tone_kill    = 1'b1;
                                mode_next    = MODE_IDLE;
                                pos_next     = '0;
                                len_next     = '0;
                                rep_next     = 1'b0;
                                started_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        pre_next = pre_reg + 1'b1;
                    end
                end
                ACT_WRITE:
                begin
                    // Table write happens on the RAM port
                end
                ACT_PLAY:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        tone_kill    = 1'b1;
                        mode_next    = MODE_IDLE;
                        pos_next     = '0;
                        len_next     = '0;
                        rep_next     = 1'b0;
                        started_next = 1'b0;
                    end
                    if (melody_length != '0)
                    begin
                        len_next     = (32'(melody_length) > NOTE_SLOTS)
                                       ? LEN_W'(NOTE_SLOTS) : melody_length;
                        rep_next     = repeat_flag;
                        pos_next     = '0;
                        started_next = 1'b0;
                        mode_next    = MODE_PLAYING;
                    end
                end
                ACT_STOP:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        tone_kill    = 1'b1;
                        mode_next    = MODE_IDLE;
                        pos_next     = '0;
                        len_next     = '0;
                        rep_next     = 1'b0;
                        started_next = 1'b0;
                    end
                end
                ACT_PAUSE:
                begin
                    if (mode_reg == MODE_PLAYING)
                    begin
                        tone_kill = 1'b1;
                        mode_next = MODE_PAUSED;
                    end
                end
                ACT_RESUME:
                begin
                    if (mode_reg == MODE_PAUSED)
                    begin
                        mode_next    = MODE_PLAYING;
                        started_next = 1'b0;
                    end
                end
                ACT_TONE:
                begin
                    // The old tone stops; the new one follows the division
                    tone_kill     = 1'b1;
                    pend_dur_next = duration_ms;
                end
                default:
                begin
                end
            endcase
        end

        // Note step with the table entry on the read port
        if (cmd.note_eval)
        begin
            if (!started_reg)
            begin
                tone_kill     = 1'b1;
                pend_dur_next = entry_dur;
                started_next  = 1'b1;
                note_el_next  = '0;
            end
            else if (note_el_reg >= entry_dur)
            begin
                pos_next     = pos_reg + 1'b1;
                started_next = 1'b0;
                tone_kill    = 1'b1;
            end
        end

        if (tone_kill)
        begin
            active_next = 1'b0;
            timed_next  = 1'b0;
            limit_next  = '0;
            pin_next    = 1'b0;
        end

        // Tone start once the half period is known and in range
        if (div_done && hp_ok)
        begin
            hp_next      = div_quo[HP_W-1:0];
            tcount_next  = '0;
            active_next  = 1'b1;
            tone_el_next = '0;
            timed_next   = pend_dur_reg != '0;
            limit_next   = pend_dur_reg;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RST;
            tpm_reg      <= TICKS_MS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CLOCK_HZ)
            begin
                clock_hz_reg <= cfg_data;
            end
            if (cfg_index == CFG_TICKS_MS)
            begin
                tpm_reg <= cfg_data[TPM_W-1:0];
            end
        end
    end

    // Melody and tone state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            rep_reg     <= 1'b0;
            started_reg <= 1'b0;
            note_el_reg <= '0;
            pre_reg     <= '0;
            active_reg  <= 1'b0;
            timed_reg   <= 1'b0;
            tone_el_reg <= '0;
            limit_reg   <= '0;
            hp_reg      <= '0;
            tcount_reg  <= '0;
            pin_reg     <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            rep_reg     <= rep_next;
            started_reg <= started_next;
            note_el_reg <= note_el_next;
            pre_reg     <= pre_next;
            active_reg  <= active_next;
            timed_reg   <= timed_next;
            tone_el_reg <= tone_el_next;
            limit_reg   <= limit_next;
            hp_reg      <= hp_next;
            tcount_reg  <= tcount_next;
            pin_reg     <= pin_next;
        end
    end

    // Pending tone duration and result item capture
    always_ff @(posedge clk)
    begin
        pend_dur_reg <= pend_dur_next;
        if (cmd.load_out)
        begin
            out_pin_reg  <= pin_next;
            out_tone_reg <= active_next;
            out_mode_reg <= mode_next;
            out_note_reg <= pos_next;
        end
    end

    assign pin_level    = out_pin_reg;
    assign tone_on      = out_tone_reg;
    assign play_mode    = out_mode_reg;
    assign current_note = out_note_reg;

`ifndef SYNTH
    // The pin is only ever high while a tone runs
    a_pin_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
        pin_reg |-> active_reg)
        else $error("pin high without an active tone");

    // A running tone always has a legal half period
    a_tone_half_period: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (hp_reg != '0))
        else $error("active tone with zero half period");

    // An idle sequencer holds a cleared melody position
    a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (pos_reg == '0 && len_reg == '0 && !started_reg))
        else $error("idle sequencer with melody state left over");

    // A loaded melody has a legal length and the position never passes it
    a_melody_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |->
            (len_reg != '0 && len_reg <= LEN_W'(NOTE_SLOTS) && pos_reg <= len_reg))
        else $error("melody length or position out of bounds");
`endif

endmodule
`default_nettype wire

// ----- rtl/mts_ctrl.sv -----
// Controller: item sequencing, note table read wait, division wait, result hand-off.
`default_nettype none
module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    output logic          result_valid,
    input  wire logic     result_ready,
    input  wire mts_sts_t sts,
    output mts_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NOTE,
        S_DIV,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register is free when empty or being taken this cycle
    assign out_free   = !out_valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE) && out_free;

    // Sequencing of one item
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    cmd.exec = 1'b1;
                    if (sts.item_read)
                    begin
                        state_next = S_NOTE;
                    end
                    else if (sts.item_div)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                    end
                end
            end
            S_NOTE:
            begin
                cmd.note_eval = 1'b1;
                if (sts.note_div)
                begin
                    state_next = S_DIV;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/melody_tone_sequencer_core.sv -----
// Top level of the melody tone sequencer: controller, datapath and channel wiring.
//
// Usage: items arrive on the items channel (valid/ready); every accepted item
// gives exactly one result item on the results channel, reporting pin level,
// tone state, play mode and current note after the item. Tick items are
// timer clocks; the other actions write a note slot, play, stop, pause,
// resume or start a single tone. The cfg channel writes the timer clock rate
// (index 0) and ticks per millisecond (index 1); it is always ready. The user
// must write it only while no item is in flight; the block does not enforce it.
// Most items are handled in the idle state that accepts them. A tick on a
// millisecond boundary while a melody plays also waits for the note table
// RAM read, which is registered. Any item that starts a tone also waits for
// the half period, which a shared divider works out one quotient bit per
// cycle over the 25-bit clock rate.
// The result register parts the channels: a new item is accepted while a
// result waits, as long as that result is taken in the same cycle or the
// register is empty; a stalled receiver holds further items back.
// Reset clears control, melody and tone state, stops any tone, sets pin_reg low
// and loads the default configuration; the note table is undefined until written.
`default_nettype none
module melody_tone_sequencer_core
    import mts_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mts_item_if.sink   items,
    mts_result_if.source results,
    mts_cfg_if.sink    cfg
);

    mts_cmd_t cmd;
    mts_sts_t sts;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    mts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (items.valid),
        .item_ready   (items.ready),
        .result_valid (results.valid),
        .result_ready (results.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    mts_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .action        (items.action),
        .note_slot     (items.note_slot),
        .frequency     (items.frequency),
        .duration_ms   (items.duration_ms),
        .melody_length (items.melody_length),
        .repeat_flag   (items.repeat_flag),
        .pin_level     (results.pin_level),
        .tone_on       (results.tone_on),
        .play_mode     (results.play_mode),
        .current_note  (results.current_note)
    );

endmodule
`default_nettype wire
